### hdl/assert_macros.svh
// Assertion macros shared by the record ring FIFO RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check a condition at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// Check that a condition implies another in the same cycle
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Check that a condition implies another in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg)
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

### hdl/rrf_pkg.sv
// Types and constants shared by the record ring FIFO modules.
// No dependencies.
package rrf_pkg;

   // Field widths of requests and results
   localparam int STATUS_W = 3;
   localparam int BYTE_W8  = 8;
   localparam int LEN_W    = 6;
   localparam int HELD_W   = 5;
   localparam int SLOTS_CFG_W = 5;
   localparam int SLOT_FIELD_W = 8;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_BYTE   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_COMMIT = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_LONG   = 3'd4;

   // Request types
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_READ  = 1'b1;

   // Configuration register indexes and reset values
   localparam logic CSR_SLOTS = 1'b0;
   localparam logic CSR_BYTES = 1'b1;
   localparam logic [SLOTS_CFG_W-1:0] SLOTS_CFG_RESET = 5'd16;
   localparam logic [LEN_W-1:0]       BYTES_CFG_RESET = 6'd32;

   // Queue depths
   localparam int CMDQ_DEPTH = 2;
   localparam int ODEPTH     = 4;

   typedef enum logic [1:0] {
      REJ_NONE,
      REJ_FULL,
      REJ_LONG
   } rrf_rej_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_LEN,
      BK_STREAM
   } rrf_back_state_type;

   // Command from front to back: a ready-made status or a record read
   typedef struct packed {
      logic                    is_read;
      logic [STATUS_W-1:0]     status;
      logic [LEN_W-1:0]        length;
      logic [HELD_W-1:0]       held;
      logic [SLOT_FIELD_W-1:0] slot;
   } rrf_cmd_type;

   // Store writes from front to back
   typedef struct packed {
      logic                    byte_we;
      logic                    len_we;
      logic [SLOT_FIELD_W-1:0] slot;
      logic [LEN_W-1:0]        pos;
      logic [BYTE_W8-1:0]      data;
      logic [LEN_W-1:0]        len;
   } rrf_wr_type;

   // One result item
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [BYTE_W8-1:0]  out_byte;
      logic [LEN_W-1:0]    length;
      logic                last;
      logic [HELD_W-1:0]   held;
   } rrf_rsp_type;

endpackage

### hdl/record_ring_fifo_unit.sv
// Top level of the record ring FIFO: front end, command queue and back end.
// Depends on rrf_pkg, rrf_front, rrf_cmd_queue and rrf_back.
//
// A ring of SLOTS record slots, each up to MAX_RECORD_BYTES bytes. Write bytes are taken one
// per cycle while full is low; the final byte gives a single commit, full or too-long status.
// A read request on an empty ring gives one empty status; otherwise the back end looks up the
// record length and then drains the oldest record one byte per cycle while the result queue
// has room, and full stays high until its last byte address is issued to the record store.
// Full also rises while the two-entry command queue between front and back is full. A status
// result passes through the command queue, the issue stage and the result queue; a read byte
// passes the command queue, length lookup, drain sequencer, issue stage and store read, then
// the result queue, which holds four entries, so pop may stall freely. Store contents are
// undefined until written and no clearing pass runs after reset.
module record_ring_fifo_unit #(
   parameter int SLOTS            = 16,
   parameter int MAX_RECORD_BYTES = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   // configuration
   input  logic                              valid,
   output logic                              ready,
   input  logic                              csr_index,
   input  logic [rrf_pkg::LEN_W-1:0]         csr_data,
   // requests
   input  logic                              push,
   output logic                              full,
   input  logic                              req_type,
   input  logic [rrf_pkg::BYTE_W8-1:0]       req_data_byte,
   input  logic                              req_last_byte,
   // results
   output logic                              empty,
   input  logic                              pop,
   output logic [rrf_pkg::STATUS_W-1:0]      rsp_status,
   output logic [rrf_pkg::BYTE_W8-1:0]       rsp_out_byte,
   output logic [rrf_pkg::LEN_W-1:0]         rsp_record_length,
   output logic                              rsp_last_out,
   output logic [rrf_pkg::HELD_W-1:0]        rsp_records_held
);

   logic                 q_full, q_push, q_valid, q_pop, read_done;
   rrf_pkg::rrf_cmd_type q_cmd, q_head;
   rrf_pkg::rrf_wr_type  wr;
   rrf_pkg::rrf_rsp_type rsp;

   // Configuration writes are always taken
   assign ready = 1'b1;

   rrf_front #(
      .SLOTS            (SLOTS),
      .MAX_RECORD_BYTES (MAX_RECORD_BYTES)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (valid),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .push          (push),
      .full          (full),
      .req_type      (req_type),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_cmd         (q_cmd),
      .wr            (wr),
      .read_done     (read_done)
   );

   rrf_cmd_queue u_cmd_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .valid    (q_valid),
      .head     (q_head)
   );

   rrf_back #(
      .SLOTS            (SLOTS),
      .MAX_RECORD_BYTES (MAX_RECORD_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .wr        (wr),
      .cmd_valid (q_valid),
      .cmd_head  (q_head),
      .cmd_pop   (q_pop),
      .read_done (read_done),
      .pop       (pop),
      .empty     (empty),
      .rsp       (rsp)
   );

   // Unpack the oldest result onto its ports
   assign rsp_status        = rsp.status;
   assign rsp_out_byte      = rsp.out_byte;
   assign rsp_record_length = rsp.length;
   assign rsp_last_out      = rsp.last;
   assign rsp_records_held  = rsp.held;

endmodule

### hdl/rrf_front.sv
// Front end of the record ring FIFO: configuration, slot pointers and request classification.
// Depends on rrf_pkg and assert_macros.svh.
`include "assert_macros.svh"
module rrf_front #(
   parameter int SLOTS            = 16,
   parameter int MAX_RECORD_BYTES = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   input  logic                                 csr_index,
   input  logic [rrf_pkg::LEN_W-1:0]            csr_data,
   input  logic                                 push,
   output logic                                 full,
   input  logic                                 req_type,
   input  logic [rrf_pkg::BYTE_W8-1:0]          req_data_byte,
   input  logic                                 req_last_byte,
   input  logic                                 q_full,
   output logic                                 q_push,
   output rrf_pkg::rrf_cmd_type                 q_cmd,
   output rrf_pkg::rrf_wr_type                  wr,
   input  logic                                 read_done
);

   localparam int SLOT_W = $clog2(SLOTS);
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam int CMP_W  = (SLOT_W + 1 > 5) ? SLOT_W + 1 : 5;

   logic [rrf_pkg::SLOTS_CFG_W-1:0] slots_cfg_ff;
   logic [rrf_pkg::LEN_W-1:0]       bytes_cfg_ff;
   logic [SLOT_W-1:0]               rslot_ff, rslot_in;
   logic [SLOT_W-1:0]               wslot_ff, wslot_in;
   logic [CNT_W-1:0]                count_ff, count_in;
   logic [rrf_pkg::LEN_W-1:0]       pos_ff, pos_in;
   rrf_pkg::rrf_rej_type            rej_ff, rej_in;
   logic                            read_busy_ff, read_busy_in;

   logic [CMP_W-1:0]                eff_slots;
   logic [rrf_pkg::LEN_W-1:0]       eff_bytes;
   logic                            accept;

   // Step a slot pointer, wrapping at the slots in use
   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s,
                                                    input logic [CMP_W-1:0]  lim);
      logic [CMP_W-1:0] n;
      n = CMP_W'(s) + CMP_W'(1);
      return (n >= lim) ? '0 : SLOT_W'(n);
   endfunction

   // Hold the configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         slots_cfg_ff <= rrf_pkg::SLOTS_CFG_RESET;
         bytes_cfg_ff <= rrf_pkg::BYTES_CFG_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            rrf_pkg::CSR_SLOTS: slots_cfg_ff <= csr_data[rrf_pkg::SLOTS_CFG_W-1:0];
            rrf_pkg::CSR_BYTES: bytes_cfg_ff <= csr_data;
            default:            slots_cfg_ff <= slots_cfg_ff;
         endcase
      end
   end

   // Saturate the registers to the sizes the storage supports; a zero register counts as one
   always_comb begin
      if (slots_cfg_ff == '0) begin
         eff_slots = CMP_W'(1);
      end else if (CMP_W'(slots_cfg_ff) > CMP_W'(SLOTS)) begin
         eff_slots = CMP_W'(SLOTS);
      end else begin
         eff_slots = CMP_W'(slots_cfg_ff);
      end
      if (bytes_cfg_ff == '0) begin
         eff_bytes = rrf_pkg::LEN_W'(1);
      end else if (7'(bytes_cfg_ff) > 7'(MAX_RECORD_BYTES)) begin
         eff_bytes = rrf_pkg::LEN_W'(MAX_RECORD_BYTES);
      end else begin
         eff_bytes = bytes_cfg_ff;
      end
   end

   // Hold off requests while a record drains or the command queue is full
   assign full   = q_full | read_busy_ff;
   assign accept = push & ~full;

   // Classify each request and update the ring state
   always_comb begin
      logic                 first;
      rrf_pkg::rrf_rej_type rej_v;
      logic [rrf_pkg::LEN_W-1:0] pos_v;
      logic [SLOT_W-1:0]    rs;

      rslot_in     = rslot_ff;
      wslot_in     = wslot_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      rej_in       = rej_ff;
      read_busy_in = read_busy_ff & ~read_done;
      q_push       = 1'b0;
      q_cmd        = '0;
      wr           = '0;
      wr.slot      = rrf_pkg::SLOT_FIELD_W'(wslot_ff);
      wr.pos       = pos_ff;
      wr.data      = req_data_byte;
      first        = (pos_ff == '0) && (rej_ff == rrf_pkg::REJ_NONE);
      rej_v        = rej_ff;
      pos_v        = pos_ff;
      rs           = next_slot(rslot_ff, eff_slots);

      if (accept && req_type == rrf_pkg::REQ_WRITE) begin
         // Full check on the first byte, length check on every stored byte
         if (first && CMP_W'(count_ff) >= eff_slots) begin
            rej_v = rrf_pkg::REJ_FULL;
         end
         if (rej_v == rrf_pkg::REJ_NONE) begin
            if (pos_ff >= eff_bytes) begin
               rej_v = rrf_pkg::REJ_LONG;
            end else begin
               wr.byte_we = 1'b1;
               pos_v      = pos_ff + rrf_pkg::LEN_W'(1);
            end
         end
         pos_in = pos_v;
         rej_in = rej_v;
         if (req_last_byte) begin
            q_push       = 1'b1;
            q_cmd.is_read = 1'b0;
            pos_in       = '0;
            rej_in       = rrf_pkg::REJ_NONE;
            if (rej_v == rrf_pkg::REJ_NONE) begin
               // Commit the record
               wr.len_we    = 1'b1;
               wr.len       = pos_v;
               wslot_in     = next_slot(wslot_ff, eff_slots);
               count_in     = count_ff + CNT_W'(1);
               q_cmd.status = rrf_pkg::ST_COMMIT;
               q_cmd.length = pos_v;
               q_cmd.held   = rrf_pkg::HELD_W'(count_ff + CNT_W'(1));
            end else begin
               // Drop the record and report why
               q_cmd.status = (rej_v == rrf_pkg::REJ_FULL) ? rrf_pkg::ST_FULL
                                                           : rrf_pkg::ST_LONG;
               q_cmd.held   = rrf_pkg::HELD_W'(count_ff);
            end
         end
      end else if (accept) begin
         q_push = 1'b1;
         if (count_ff == '0) begin
            q_cmd.status = rrf_pkg::ST_EMPTY;
            q_cmd.held   = '0;
         end else begin
            // Hand the oldest slot to the back end and advance
            q_cmd.is_read = 1'b1;
            q_cmd.status  = rrf_pkg::ST_BYTE;
            q_cmd.slot    = rrf_pkg::SLOT_FIELD_W'(rslot_ff);
            q_cmd.held    = rrf_pkg::HELD_W'(count_ff - CNT_W'(1));
            count_in      = count_ff - CNT_W'(1);
            read_busy_in  = 1'b1;
            if (rs == wslot_ff && pos_ff == '0) begin
               rslot_in = '0;
               wslot_in = '0;
            end else begin
               rslot_in = rs;
            end
         end
      end
   end

   // Hold the ring state
   always_ff @(posedge clock) begin
      if (reset) begin
         rslot_ff     <= '0;
         wslot_ff     <= '0;
         count_ff     <= '0;
         pos_ff       <= '0;
         rej_ff       <= rrf_pkg::REJ_NONE;
         read_busy_ff <= 1'b0;
      end else begin
         rslot_ff     <= rslot_in;
         wslot_ff     <= wslot_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         rej_ff       <= rej_in;
         read_busy_ff <= read_busy_in;
      end
   end

   `ASSERT_IMPLY(a_wr_while_idle, clock, reset, wr.byte_we, !read_busy_ff, "byte stored during drain")
   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(SLOTS), "record count overflow")
   `ASSERT_IMPLY(a_full_rej_pos, clock, reset, rej_ff == rrf_pkg::REJ_FULL, pos_ff == '0, "full reject with bytes")

endmodule

### hdl/rrf_cmd_queue.sv
// Short command queue between the front and back ends of the record ring FIFO.
// Depends on rrf_pkg.
module rrf_cmd_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  rrf_pkg::rrf_cmd_type push_cmd,
   output logic                 full,
   input  logic                 pop,
   output logic                 valid,
   output rrf_pkg::rrf_cmd_type head
);

   localparam int PTR_W = $clog2(rrf_pkg::CMDQ_DEPTH);
   localparam int CNT_W = $clog2(rrf_pkg::CMDQ_DEPTH + 1);

   rrf_pkg::rrf_cmd_type entry_ff [rrf_pkg::CMDQ_DEPTH];
   logic [PTR_W-1:0]     wptr_ff, wptr_in;
   logic [PTR_W-1:0]     rptr_ff, rptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 do_push, do_pop;

   assign full    = (count_ff == CNT_W'(rrf_pkg::CMDQ_DEPTH));
   assign valid   = (count_ff != '0);
   assign head    = entry_ff[rptr_ff];
   assign do_push = push & ~full;
   assign do_pop  = pop & valid;

   // Advance the pointers with wrap
   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == PTR_W'(rrf_pkg::CMDQ_DEPTH - 1)) ? '0 : wptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == PTR_W'(rrf_pkg::CMDQ_DEPTH - 1)) ? '0 : rptr_ff + PTR_W'(1);
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   // Store the incoming command
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wptr_ff] <= push_cmd;
      end
   end

endmodule

### hdl/rrf_back.sv
// Back end of the record ring FIFO: record and length stores, drain sequencer, result queue.
// Depends on rrf_pkg and assert_macros.svh.
`include "assert_macros.svh"
module rrf_back #(
   parameter int SLOTS            = 16,
   parameter int MAX_RECORD_BYTES = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rrf_pkg::rrf_wr_type  wr,
   input  logic                 cmd_valid,
   input  rrf_pkg::rrf_cmd_type cmd_head,
   output logic                 cmd_pop,
   output logic                 read_done,
   input  logic                 pop,
   output logic                 empty,
   output rrf_pkg::rrf_rsp_type rsp
);

   localparam int SLOT_W = $clog2(SLOTS);
   localparam int BYTE_W = (MAX_RECORD_BYTES > 1) ? $clog2(MAX_RECORD_BYTES) : 1;
   localparam int ADDR_W = SLOT_W + BYTE_W;
   localparam int DEPTH  = SLOTS * (2 ** BYTE_W);
   localparam int OPTR_W = $clog2(rrf_pkg::ODEPTH);
   localparam int OCNT_W = $clog2(rrf_pkg::ODEPTH + 1);

   logic [rrf_pkg::BYTE_W8-1:0] store_mem [DEPTH];
   logic [rrf_pkg::LEN_W-1:0]   len_mem [SLOTS];
   logic [rrf_pkg::BYTE_W8-1:0] byte_rd_ff;
   logic [rrf_pkg::LEN_W-1:0]   len_rd_ff;

   rrf_pkg::rrf_back_state_type state_ff, state_in;
   logic [SLOT_W-1:0]           slot_ff, slot_in;
   logic [rrf_pkg::HELD_W-1:0]  held_ff, held_in;
   logic [rrf_pkg::LEN_W-1:0]   len_ff, len_in;
   logic [rrf_pkg::LEN_W-1:0]   idx_ff, idx_in;

   logic                        p_valid_ff, p_valid_in;
   rrf_pkg::rrf_rsp_type        p_ff, p_in;
   logic                        p_is_byte_ff, p_is_byte_in;

   rrf_pkg::rrf_rsp_type        ofifo_ff [rrf_pkg::ODEPTH];
   logic [OPTR_W-1:0]           owptr_ff, orptr_ff;
   logic [OCNT_W-1:0]           ocount_ff;
   logic                        out_pop;
   logic                        credit_ok;
   logic [ADDR_W-1:0]           wr_addr, rd_addr;
   rrf_pkg::rrf_rsp_type        push_entry;

   assign wr_addr = {wr.slot[SLOT_W-1:0], wr.pos[BYTE_W-1:0]};
   assign rd_addr = {slot_ff, idx_ff[BYTE_W-1:0]};

   // Write and read the record and length stores
   always_ff @(posedge clock) begin
      if (wr.byte_we) begin
         store_mem[wr_addr] <= wr.data;
      end
      if (wr.len_we) begin
         len_mem[wr.slot[SLOT_W-1:0]] <= wr.len;
      end
      byte_rd_ff <= store_mem[rd_addr];
      len_rd_ff  <= len_mem[cmd_head.slot[SLOT_W-1:0]];
   end

   // Issue only when the result queue has room for everything in flight
   assign credit_ok = ((OCNT_W + 1)'(ocount_ff) + (OCNT_W + 1)'(p_valid_ff))
                      < (OCNT_W + 1)'(rrf_pkg::ODEPTH);

   // Sequence commands: pass statuses, look up length, then drain bytes
   always_comb begin
      logic last;
      state_in     = state_ff;
      slot_in      = slot_ff;
      held_in      = held_ff;
      len_in       = len_ff;
      idx_in       = idx_ff;
      cmd_pop      = 1'b0;
      read_done    = 1'b0;
      p_valid_in   = 1'b0;
      p_in         = '0;
      p_is_byte_in = 1'b0;
      last         = (rrf_pkg::LEN_W'(idx_ff + rrf_pkg::LEN_W'(1)) == len_ff);
      case (state_ff)
         rrf_pkg::BK_IDLE: begin
            if (cmd_valid && credit_ok) begin
               cmd_pop = 1'b1;
               if (cmd_head.is_read) begin
                  slot_in  = cmd_head.slot[SLOT_W-1:0];
                  held_in  = cmd_head.held;
                  state_in = rrf_pkg::BK_LEN;
               end else begin
                  p_valid_in  = 1'b1;
                  p_in.status = cmd_head.status;
                  p_in.length = cmd_head.length;
                  p_in.last   = 1'b1;
                  p_in.held   = cmd_head.held;
               end
            end
         end
         rrf_pkg::BK_LEN: begin
            if (len_rd_ff == '0) begin
               read_done = 1'b1;
               state_in  = rrf_pkg::BK_IDLE;
            end else begin
               len_in   = len_rd_ff;
               idx_in   = '0;
               state_in = rrf_pkg::BK_STREAM;
            end
         end
         rrf_pkg::BK_STREAM: begin
            if (credit_ok) begin
               p_valid_in   = 1'b1;
               p_is_byte_in = 1'b1;
               p_in.status  = rrf_pkg::ST_BYTE;
               p_in.length  = len_ff;
               p_in.last    = last;
               p_in.held    = held_ff;
               idx_in       = idx_ff + rrf_pkg::LEN_W'(1);
               if (last) begin
                  read_done = 1'b1;
                  state_in  = rrf_pkg::BK_IDLE;
               end
            end
         end
         default: begin
            state_in = rrf_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= rrf_pkg::BK_IDLE;
         p_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         p_valid_ff <= p_valid_in;
      end
   end

   // Hold the drain context and the issue stage
   always_ff @(posedge clock) begin
      slot_ff      <= slot_in;
      held_ff      <= held_in;
      len_ff       <= len_in;
      idx_ff       <= idx_in;
      p_ff         <= p_in;
      p_is_byte_ff <= p_is_byte_in;
   end

   // Merge the store read data into the issued result
   always_comb begin
      push_entry          = p_ff;
      push_entry.out_byte = p_is_byte_ff ? byte_rd_ff : '0;
   end

   // Result queue
   assign empty   = (ocount_ff == '0);
   assign rsp     = ofifo_ff[orptr_ff];
   assign out_pop = pop & ~empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         owptr_ff  <= '0;
         orptr_ff  <= '0;
         ocount_ff <= '0;
      end else begin
         if (p_valid_ff) begin
            owptr_ff <= (owptr_ff == OPTR_W'(rrf_pkg::ODEPTH - 1)) ? '0
                                                                   : owptr_ff + OPTR_W'(1);
         end
         if (out_pop) begin
            orptr_ff <= (orptr_ff == OPTR_W'(rrf_pkg::ODEPTH - 1)) ? '0
                                                                   : orptr_ff + OPTR_W'(1);
         end
         case ({p_valid_ff, out_pop})
            2'b10:   ocount_ff <= ocount_ff + OCNT_W'(1);
            2'b01:   ocount_ff <= ocount_ff - OCNT_W'(1);
            default: ocount_ff <= ocount_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (p_valid_ff) begin
         ofifo_ff[owptr_ff] <= push_entry;
      end
   end

   `ASSERT_ALWAYS(a_ocount_bound, clock, reset, ocount_ff <= OCNT_W'(rrf_pkg::ODEPTH), "result queue overflow")
   `ASSERT_ALWAYS(a_credit, clock, reset, ((OCNT_W + 1)'(ocount_ff) + (OCNT_W + 1)'(p_valid_ff)) <= (OCNT_W + 1)'(rrf_pkg::ODEPTH), "issue beyond credit")
   `ASSERT_IMPLY(a_stream_idx, clock, reset, state_ff == rrf_pkg::BK_STREAM, idx_ff < len_ff, "drain index past length")
   `ASSERT_NEXT(a_len_to_stream, clock, reset, state_ff == rrf_pkg::BK_LEN && len_rd_ff != '0, state_ff == rrf_pkg::BK_STREAM && idx_ff == '0, "drain did not start")

endmodule

### tb/tb_top.sv
// Self-checking testbench for record_ring_fifo_unit: directed and random record traffic.
// Depends on rrf_pkg and the record ring FIFO RTL; predicts each result in-line.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS       = 16;
   localparam int MAX_BYTES   = 32;
   localparam int CLK_PERIOD  = 12;
   localparam int RESET_CYCLES = 12;
   localparam int CSR_SETTLE  = 10;
   localparam int END_SETTLE  = 20;
   localparam int HOLD_CYCLES = 300;
   localparam int STALL_LIMIT = 4000;
   localparam int PHASE_ITEMS = 24;

   logic clock = 1'b0;
   logic reset;
   logic valid, ready, csr_index;
   logic [rrf_pkg::LEN_W-1:0] csr_data;
   logic push, full, req_type, req_last_byte;
   logic [rrf_pkg::BYTE_W8-1:0] req_data_byte;
   logic empty, pop;
   logic [rrf_pkg::STATUS_W-1:0] rsp_status;
   logic [rrf_pkg::BYTE_W8-1:0] rsp_out_byte;
   logic [rrf_pkg::LEN_W-1:0] rsp_record_length;
   logic rsp_last_out;
   logic [rrf_pkg::HELD_W-1:0] rsp_records_held;

   // Predicted ring contents, pointers and registers
   logic [7:0] ring_data [SLOTS][MAX_BYTES];
   logic [5:0] ring_len [SLOTS];
   bit slot_filled [SLOTS];
   int rd_slot, wr_slot, held_count, wr_pos;
   rrf_pkg::rrf_rej_type wr_rej;
   logic [4:0] cfg_slots;
   logic [5:0] cfg_bytes;

   rrf_pkg::rrf_rsp_type due_results [$];
   int bad_count = 0;
   int items_sent;
   int burst_left;
   int holds_asked, holds_served;
   int idle_cycles = 0;

   record_ring_fifo_unit #(
      .SLOTS(SLOTS),
      .MAX_RECORD_BYTES(MAX_BYTES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .valid(valid),
      .ready(ready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .push(push),
      .full(full),
      .req_type(req_type),
      .req_data_byte(req_data_byte),
      .req_last_byte(req_last_byte),
      .empty(empty),
      .pop(pop),
      .rsp_status(rsp_status),
      .rsp_out_byte(rsp_out_byte),
      .rsp_record_length(rsp_record_length),
      .rsp_last_out(rsp_last_out),
      .rsp_records_held(rsp_records_held)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Saturate the registers to their usable ranges
   function automatic int eff_slots();
      if (cfg_slots < 1) return 1;
      if (cfg_slots > SLOTS) return SLOTS;
      return int'(cfg_slots);
   endfunction

   function automatic int eff_bytes();
      if (cfg_bytes < 1) return 1;
      if (cfg_bytes > MAX_BYTES) return MAX_BYTES;
      return int'(cfg_bytes);
   endfunction

   function automatic int next_slot(int s);
      return (s + 1 >= eff_slots()) ? 0 : s + 1;
   endfunction

   function automatic rrf_pkg::rrf_rsp_type make_rsp(logic [2:0] st, logic [7:0] b, int len,
                                                      logic last);
      rrf_pkg::rrf_rsp_type r;
      r.status   = st;
      r.out_byte = b;
      r.length   = len[5:0];
      r.last     = last;
      r.held     = held_count[4:0];
      return r;
   endfunction

   // Advance the predicted ring by one accepted request and queue its results
   task automatic ring_apply_request(logic typ, logic [7:0] data, logic last);
      int slot, len;
      if (typ == rrf_pkg::REQ_WRITE) begin
         // full check only at the first byte of a record
         if (wr_pos == 0 && wr_rej == rrf_pkg::REJ_NONE && held_count >= eff_slots())
            wr_rej = rrf_pkg::REJ_FULL;
         if (wr_rej == rrf_pkg::REJ_NONE) begin
            if (wr_pos >= eff_bytes()) begin
               wr_rej = rrf_pkg::REJ_LONG;
            end else begin
               ring_data[wr_slot][wr_pos] = data;
               wr_pos++;
            end
         end
         if (last) begin
            if (wr_rej == rrf_pkg::REJ_NONE) begin
               ring_len[wr_slot] = wr_pos[5:0];
               slot_filled[wr_slot] = 1'b1;
               wr_slot = next_slot(wr_slot);
               held_count++;
               due_results.push_back(make_rsp(rrf_pkg::ST_COMMIT, 8'h00, wr_pos, 1'b1));
               wr_pos = 0;
            end else begin
               due_results.push_back(make_rsp((wr_rej == rrf_pkg::REJ_FULL) ?
                                              rrf_pkg::ST_FULL : rrf_pkg::ST_LONG,
                                              8'h00, 0, 1'b1));
               wr_pos = 0;
               wr_rej = rrf_pkg::REJ_NONE;
            end
         end
      end else if (held_count == 0) begin
         due_results.push_back(make_rsp(rrf_pkg::ST_EMPTY, 8'h00, 0, 1'b1));
      end else begin
         slot = rd_slot;
         len = int'(ring_len[slot]);
         held_count--;
         rd_slot = next_slot(rd_slot);
         // pointers meet: return both to slot zero unless a record is half written
         if (rd_slot == wr_slot && wr_pos == 0) begin
            rd_slot = 0;
            wr_slot = 0;
         end
         for (int i = 0; i < len; i++)
            due_results.push_back(make_rsp(rrf_pkg::ST_BYTE, ring_data[slot][i], len,
                                           (i + 1 == len)));
      end
   endtask

   // Offer one request, hold it until taken, then maybe pause between bursts
   task automatic send_request(logic typ, logic [7:0] data, logic last);
      int gap;
      push <= 1'b1;
      req_type <= typ;
      req_data_byte <= data;
      req_last_byte <= last;
      do @(posedge clock); while (full);
      ring_apply_request(typ, data, last);
      items_sent++;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(4) == 0) ? 80 : $urandom_range(1, 16);
         gap = $urandom_range(1, 6);
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Read the oldest record; skip a read that would reach a never-written slot
   task automatic send_read();
      if (held_count > 0 && !slot_filled[rd_slot]) return;
      send_request(rrf_pkg::REQ_READ, 8'($urandom_range(255)), 1'($urandom_range(1)));
   endtask

   task automatic send_random_record();
      int n, lim;
      lim = eff_bytes();
      case ($urandom_range(9))
         0: n = lim + $urandom_range(1, 3);
         1, 2: n = $urandom_range(1, lim);
         default: n = $urandom_range(1, (lim < 4) ? lim : 4);
      endcase
      for (int i = 0; i < n; i++) begin
         // occasionally drain a record while this one is still arriving
         if (i > 0 && $urandom_range(11) == 0) send_read();
         send_request(rrf_pkg::REQ_WRITE, 8'($urandom_range(255)), (i == n - 1));
      end
   endtask

   // Drain outstanding results, let the block settle, then write both registers
   task automatic set_config(logic [5:0] slots_val, logic [5:0] bytes_val);
      push <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (CSR_SETTLE) @(posedge clock);
      valid <= 1'b1;
      csr_index <= rrf_pkg::CSR_SLOTS;
      csr_data <= slots_val;
      do @(posedge clock); while (!ready);
      cfg_slots = slots_val[4:0];
      csr_index <= rrf_pkg::CSR_BYTES;
      csr_data <= bytes_val;
      do @(posedge clock); while (!ready);
      cfg_bytes = bytes_val;
      valid <= 1'b0;
   endtask

   // Empty reads, single and multi-byte records, pointer return to zero
   task automatic test_basic_records();
      send_read();
      send_request(rrf_pkg::REQ_WRITE, 8'h00, 1'b1);
      send_request(rrf_pkg::REQ_WRITE, 8'hFF, 1'b0);
      send_request(rrf_pkg::REQ_WRITE, 8'hA5, 1'b0);
      send_request(rrf_pkg::REQ_WRITE, 8'h5A, 1'b1);
      repeat (3) send_read();
   endtask

   // Record over the length limit is dropped, then a record at the limit
   task automatic test_too_long();
      set_config(6'd16, 6'd2);
      for (int i = 0; i < 4; i++)
         send_request(rrf_pkg::REQ_WRITE, 8'(8'h10 + i), (i == 3));
      send_request(rrf_pkg::REQ_WRITE, 8'h81, 1'b0);
      send_request(rrf_pkg::REQ_WRITE, 8'h7E, 1'b1);
      send_read();
   endtask

   // Zero slots saturate to one; a read mid-record keeps the full rejection
   task automatic test_full_reject();
      set_config(6'd0, 6'd2);
      send_request(rrf_pkg::REQ_WRITE, 8'h3C, 1'b1);
      send_request(rrf_pkg::REQ_WRITE, 8'hC3, 1'b0);
      send_read();
      send_request(rrf_pkg::REQ_WRITE, 8'h99, 1'b1);
      send_read();
   endtask

   // Read while a record is half written: pointers must not return to zero
   task automatic test_read_mid_record();
      set_config(6'd2, 6'd32);
      send_request(rrf_pkg::REQ_WRITE, 8'h01, 1'b1);
      send_request(rrf_pkg::REQ_WRITE, 8'h02, 1'b0);
      send_read();
      send_request(rrf_pkg::REQ_WRITE, 8'h03, 1'b1);
      send_read();
   endtask

   // Hold off the receiver while one record more than the slot count is written
   task automatic test_backpressure();
      set_config(6'd31, 6'd63);
      holds_asked++;
      for (int i = 0; i <= SLOTS; i++)
         send_request(rrf_pkg::REQ_WRITE, 8'($urandom_range(255)), 1'b1);
      for (int i = 0; i <= SLOTS; i++) send_read();
   endtask

   // Random record traffic over several register settings
   task automatic test_random_traffic();
      logic [5:0] slot_set [6];
      logic [5:0] byte_set [6];
      int start, read_pct;
      slot_set = '{6'd16, 6'd3, 6'd1, 6'd7, 6'd16, 6'd0};
      byte_set = '{6'd32, 6'd5, 6'd1, 6'd40, 6'd8, 6'd0};
      slot_set[5] = 6'($urandom_range(63));
      byte_set[5] = 6'($urandom_range(63));
      for (int p = 0; p < 6; p++) begin
         set_config(slot_set[p], byte_set[p]);
         read_pct = (p == 4) ? 10 : $urandom_range(15, 50);
         start = items_sent;
         while (items_sent - start < PHASE_ITEMS) begin
            if ($urandom_range(99) < read_pct) send_read();
            else send_random_record();
         end
      end
   endtask

   // Compare each accepted result with the oldest prediction
   always @(posedge clock) begin : check_results
      rrf_pkg::rrf_rsp_type got, want;
      if (!reset && pop && !empty) begin
         got.status   = rsp_status;
         got.out_byte = rsp_out_byte;
         got.length   = rsp_record_length;
         got.last     = rsp_last_out;
         got.held     = rsp_records_held;
         if (due_results.size() == 0) begin
            $display("%0t: unexpected result st=%0d byte=%02h len=%0d last=%0d held=%0d",
                     $time, got.status, got.out_byte, got.length, got.last, got.held);
            bad_count++;
         end else begin
            want = due_results.pop_front();
            if (got !== want) begin
               $display("%0t: mismatch expected st=%0d byte=%02h len=%0d last=%0d held=%0d",
                        $time, want.status, want.out_byte, want.length, want.last,
                        want.held);
               $display("%0t:          actual   st=%0d byte=%02h len=%0d last=%0d held=%0d",
                        $time, got.status, got.out_byte, got.length, got.last, got.held);
               bad_count++;
            end
         end
      end
   end

   // Receiver: stretches of random pop density, plus long hold-offs on request
   initial begin : result_drain
      int stretch, pct;
      stretch = 0;
      pct = 100;
      holds_served = 0;
      pop <= 1'b0;
      forever begin
         @(posedge clock);
         if (holds_served != holds_asked) begin
            pop <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
            holds_served++;
         end else begin
            if (stretch == 0) begin
               stretch = $urandom_range(8, 60);
               case ($urandom_range(3))
                  0: pct = 100;
                  1: pct = 70;
                  2: pct = 40;
                  default: pct = 10;
               endcase
            end
            stretch--;
            pop <= ($urandom_range(99) < pct);
         end
      end
   end

   // Watchdog: end the run if nothing is accepted for too long
   always @(posedge clock) begin
      if ((push && !full) || (pop && !empty) || (valid && ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      items_sent = 0;
      burst_left = 1;
      holds_asked = 0;
      rd_slot = 0;
      wr_slot = 0;
      held_count = 0;
      wr_pos = 0;
      wr_rej = rrf_pkg::REJ_NONE;
      cfg_slots = rrf_pkg::SLOTS_CFG_RESET;
      cfg_bytes = rrf_pkg::BYTES_CFG_RESET;
      foreach (slot_filled[i]) slot_filled[i] = 1'b0;
      reset <= 1'b1;
      valid <= 1'b0;
      csr_index <= rrf_pkg::CSR_SLOTS;
      csr_data <= '0;
      push <= 1'b0;
      req_type <= rrf_pkg::REQ_WRITE;
      req_data_byte <= '0;
      req_last_byte <= 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_basic_records();
      test_too_long();
      test_full_reject();
      test_read_mid_record();
      test_backpressure();
      test_random_traffic();

      // drain every outstanding result, then settle
      push <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (END_SETTLE) @(posedge clock);
      if (bad_count == 0 && due_results.size() == 0 && empty)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
